### rtl/core/framed_packet_checksum_validator_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the framed packet checksum validator
// Concurrent property helpers used by the checks in the validator unit.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_CHECKSUM_VALIDATOR_UNIT_DEFINES_SVH
`define FRAMED_PACKET_CHECKSUM_VALIDATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FPCV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FPCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/fpcv_pkg.sv
// ----------------------------------------------------------------------------
// fpcv_pkg
// Types, constants and helper functions of the framed packet checksum
// validator.
// ----------------------------------------------------------------------------
package fpcv_pkg;

    // Frame geometry
    localparam int FRAME_BYTES = 64;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 6;
    localparam int DIST_W   = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
    localparam logic [DIST_W-1:0]  DIST_TWO  = DIST_W'(2);

    // Character codes
    localparam logic [BYTE_W-1:0] SENDER_A   = 8'hA1;
    localparam logic [BYTE_W-1:0] SENDER_B   = 8'hA2;
    localparam logic [BYTE_W-1:0] SENDER_C   = 8'hA3;
    localparam logic [BYTE_W-1:0] OPEN_BR    = 8'h5B;
    localparam logic [BYTE_W-1:0] CLOSE_BR   = 8'h5D;
    localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;
    localparam logic [BYTE_W-1:0] START_RST  = 8'h24;
    localparam logic [BYTE_W-1:0] STOP_RST   = 8'h2A;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP  = 1'b1;

    // Parser phases
    typedef enum logic [2:0] {
        PH_ID    = 3'd0,
        PH_FIRST = 3'd1,
        PH_BODY  = 3'd2,
        PH_SEEK  = 3'd3,
        PH_OPEN  = 3'd4,
        PH_DONE  = 3'd5
    } t_phase;

    // Frame status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_BAD_ID   = 3'd0,
        ST_NO_START = 3'd1,
        ST_NO_STOP  = 3'd2,
        ST_NO_FIELD = 3'd3,
        ST_VALID    = 3'd4,
        ST_INVALID  = 3'd5
    } t_status;

    // One result word
    typedef struct packed {
        t_status             status;
        logic [BYTE_W-1:0]   sender_id;
        logic [COUNT_W-1:0]  body_length;
        logic [BYTE_W-1:0]   computed_sum;
        logic [BYTE_W-1:0]   received_high_char;
        logic [BYTE_W-1:0]   received_low_char;
        logic                checksum_match;
    } t_result;

    // Uppercase ASCII hex digit of a nibble
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        logic [BYTE_W-1:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

    // Accepted sender ids
    function automatic logic is_sender(input logic [BYTE_W-1:0] b);
        return (b == SENDER_A) || (b == SENDER_B) || (b == SENDER_C);
    endfunction

endpackage

### rtl/core/fpcv_in_if.sv
// ----------------------------------------------------------------------------
// fpcv_in_if
// Byte channel into the validator: valid/ready handshake with one frame byte.
// ----------------------------------------------------------------------------
interface fpcv_in_if;
    import fpcv_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_last;

    modport source (output valid, output rx_byte, output frame_last, input ready);
    modport sink   (input valid, input rx_byte, input frame_last, output ready);
endinterface

### rtl/core/fpcv_out_if.sv
// ----------------------------------------------------------------------------
// fpcv_out_if
// Result channel out of the validator: valid/ready handshake with one status.
// ----------------------------------------------------------------------------
interface fpcv_out_if;
    import fpcv_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   sender_id;
    logic [COUNT_W-1:0]  body_length;
    logic [BYTE_W-1:0]   computed_sum;
    logic [BYTE_W-1:0]   received_high_char;
    logic [BYTE_W-1:0]   received_low_char;
    logic                checksum_match;

    modport source (
        output valid, output status, output sender_id, output body_length,
        output computed_sum, output received_high_char, output received_low_char,
        output checksum_match, input ready
    );
    modport sink (
        input valid, input status, input sender_id, input body_length,
        input computed_sum, input received_high_char, input received_low_char,
        input checksum_match, output ready
    );
endinterface

### rtl/core/fpcv_parser.sv
// ----------------------------------------------------------------------------
// fpcv_parser
// Per-byte frame parser: tracks the phase, sums the body, captures the
// bracketed checksum and builds the result on the frame's final byte.
// ----------------------------------------------------------------------------
module fpcv_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [fpcv_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic                         i_frame_last,
    input  logic [fpcv_pkg::BYTE_W-1:0]  i_start_marker,
    input  logic [fpcv_pkg::BYTE_W-1:0]  i_stop_marker,
    output logic                         o_push,
    output fpcv_pkg::t_result            o_result
);
    import fpcv_pkg::*;

    // Frame state
    t_phase              r_phase, n_phase, s_phase;
    t_status             r_outcome, n_outcome;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [BYTE_W-1:0]   r_sum, n_sum;
    logic [BYTE_W-1:0]   r_sender, n_sender;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [DIST_W-1:0]   r_dist, n_dist;
    logic [BYTE_W-1:0]   r_high, n_high;
    logic [BYTE_W-1:0]   r_low, n_low;

    logic                w_last;
    logic                w_match;
    logic                w_seek;
    logic                w_open;
    t_status             w_final;

    assign w_last  = i_frame_last || (r_pos == POS_LAST);
    assign w_open  = (r_phase == PH_OPEN);
    assign w_match = (r_high == hex_char(r_sum[7:4])) && (r_low == hex_char(r_sum[3:0]));
    // bytes that go through the bracket search
    assign w_seek  = (r_phase == PH_SEEK) || w_open ||
                     ((r_phase == PH_BODY) && (i_rx_byte != NUL_BYTE) &&
                      (i_rx_byte == i_stop_marker));

    // Next state: phase and datapath update for the accepted byte
    always_comb begin
        s_phase   = r_phase;
        n_outcome = r_outcome;
        n_sum     = r_sum;
        n_sender  = r_sender;
        n_count   = r_count;
        n_dist    = r_dist;
        n_high    = r_high;
        n_low     = r_low;
        if (i_fire) begin
            if (r_phase == PH_ID) begin
                n_sum     = '0;
                n_count   = '0;
                n_dist    = '0;
                n_high    = '0;
                n_low     = '0;
                n_sender  = i_rx_byte;
                n_outcome = ST_BAD_ID;
                s_phase   = is_sender(i_rx_byte) ? PH_FIRST : PH_DONE;
            end else if (r_phase == PH_FIRST) begin
                if (i_rx_byte == i_start_marker) begin
                    if (i_rx_byte == NUL_BYTE) begin
                        s_phase   = PH_DONE;
                        n_outcome = ST_NO_STOP;
                    end else begin
                        s_phase = PH_BODY;
                    end
                end else begin
                    s_phase   = PH_DONE;
                    n_outcome = ST_NO_START;
                end
            end else if (w_seek) begin
                // bracket search; the stop byte itself joins it
                if (i_rx_byte == NUL_BYTE) begin
                    s_phase   = PH_DONE;
                    n_outcome = ST_NO_FIELD;
                end else if (i_rx_byte == OPEN_BR) begin
                    s_phase = PH_OPEN;
                    n_dist  = '0;
                end else if (i_rx_byte == CLOSE_BR) begin
                    s_phase = PH_DONE;
                    if (w_open && (r_dist == DIST_TWO)) begin
                        n_outcome = w_match ? ST_VALID : ST_INVALID;
                    end else begin
                        n_outcome = ST_NO_FIELD;
                    end
                end else begin
                    s_phase = w_open ? PH_OPEN : PH_SEEK;
                    if (w_open) begin
                        if (r_dist == '0) begin
                            n_high = i_rx_byte;
                        end
                        if (r_dist == DIST_W'(1)) begin
                            n_low = i_rx_byte;
                        end
                        if (r_dist != DIST_MAX) begin
                            n_dist = r_dist + DIST_W'(1);
                        end
                    end
                end
            end else if (r_phase == PH_BODY) begin
                if (i_rx_byte == NUL_BYTE) begin
                    s_phase   = PH_DONE;
                    n_outcome = ST_NO_STOP;
                end else begin
                    n_sum = r_sum + i_rx_byte;
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                end
            end
        end
    end

    // Outputs: settle open phases at the frame end and build the result word
    always_comb begin
        case (s_phase)
            PH_FIRST: begin
                w_final = (i_start_marker == NUL_BYTE) ? ST_NO_STOP : ST_NO_START;
            end
            PH_BODY: begin
                w_final = ST_NO_STOP;
            end
            PH_SEEK, PH_OPEN: begin
                w_final = ST_NO_FIELD;
            end
            default: begin
                w_final = n_outcome;
            end
        endcase
        o_push            = i_fire && w_last;
        o_result.status   = w_final;
        o_result.sender_id = n_sender;
        if ((w_final == ST_VALID) || (w_final == ST_INVALID)) begin
            o_result.body_length        = n_count;
            o_result.computed_sum       = n_sum;
            o_result.received_high_char = n_high;
            o_result.received_low_char  = n_low;
        end else begin
            o_result.body_length        = '0;
            o_result.computed_sum       = '0;
            o_result.received_high_char = '0;
            o_result.received_low_char  = '0;
        end
        o_result.checksum_match = (w_final == ST_VALID);
    end

    // Frame end returns to the sender id phase
    assign n_phase = (i_fire && w_last) ? PH_ID : s_phase;
    assign n_pos   = i_fire ? (w_last ? '0 : r_pos + POS_W'(1)) : r_pos;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ID;
            r_pos     <= '0;
            r_outcome <= ST_BAD_ID;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_outcome <= n_outcome;
        end
    end

    // Datapath registers, cleared (sender id loaded) by the sender id byte of each frame
    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_sender <= n_sender;
        r_count  <= n_count;
        r_dist   <= n_dist;
        r_high   <= n_high;
        r_low    <= n_low;
    end

endmodule

### rtl/core/fpcv_out_buf.sv
// ----------------------------------------------------------------------------
// fpcv_out_buf
// Result register with a skid stage, so the parser keeps taking bytes while a
// finished result waits for the consumer.
// ----------------------------------------------------------------------------
module fpcv_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fpcv_pkg::t_result i_result,
    output logic              o_in_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output fpcv_pkg::t_result o_result
);
    import fpcv_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    w_pop;

    assign w_pop      = r_out_valid && i_ready;
    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    // Fill the output register first, spill into the skid when it is held
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = i_push;
                n_skid       = i_result;
            end else begin
                n_out_valid = i_push;
                n_out       = i_result;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

### rtl/core/framed_packet_checksum_validator_unit.sv
// ----------------------------------------------------------------------------
// framed_packet_checksum_validator_unit: checks one frame of bytes per result
// Throughput: one byte per cycle while the skid stage is free; the byte path is a single register stage.
// Result: the final byte's result word is registered into the output register, or into the skid while that is held.
// Reset: synchronous, clears the parser to expect a sender id, drops results.
// ----------------------------------------------------------------------------
`include "framed_packet_checksum_validator_unit_defines.svh"

module framed_packet_checksum_validator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fpcv_in_if.sink                        i_rx,
    fpcv_out_if.source                     o_res,
    input  logic                           i_cfg_we,
    input  logic [fpcv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fpcv_pkg::BYTE_W-1:0]    i_cfg_data
);
    import fpcv_pkg::*;

    logic [BYTE_W-1:0] r_start_marker;
    logic [BYTE_W-1:0] r_stop_marker;
    logic              w_fire;
    logic              w_push;
    logic              w_in_ready;
    t_result           w_result;
    t_result           w_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_RST;
            r_stop_marker  <= STOP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START: r_start_marker <= i_cfg_data;
                CFG_STOP:  r_stop_marker  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign i_rx.ready = w_in_ready;
    assign w_fire     = i_rx.valid && w_in_ready;

    fpcv_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_rx_byte      (i_rx.rx_byte),
        .i_frame_last   (i_rx.frame_last),
        .i_start_marker (r_start_marker),
        .i_stop_marker  (r_stop_marker),
        .o_push         (w_push),
        .o_result       (w_result)
    );

    fpcv_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_result   (w_result),
        .o_in_ready (w_in_ready),
        .o_valid    (o_res.valid),
        .i_ready    (o_res.ready),
        .o_result   (w_out)
    );

    // Result word onto the channel
    assign o_res.status             = w_out.status;
    assign o_res.sender_id          = w_out.sender_id;
    assign o_res.body_length        = w_out.body_length;
    assign o_res.computed_sum       = w_out.computed_sum;
    assign o_res.received_high_char = w_out.received_high_char;
    assign o_res.received_low_char  = w_out.received_low_char;
    assign o_res.checksum_match     = w_out.checksum_match;

    // Checks
    `FPCV_ASSERT_NOW(a_match_code, i_clk, i_rst_n, o_res.valid, (o_res.checksum_match == (o_res.status == ST_VALID)), "checksum_match disagrees with status")
    `FPCV_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_res.valid && (o_res.status != ST_VALID) && (o_res.status != ST_INVALID), (o_res.body_length == '0) && (o_res.computed_sum == '0), "failed frame carries body fields")
    `FPCV_ASSERT_NOW(a_skid_order, i_clk, i_rst_n, !i_rx.ready, o_res.valid, "skid holds a word while output is empty")
    `FPCV_ASSERT_NEXT(a_last_result, i_clk, i_rst_n, i_rx.valid && i_rx.ready && i_rx.frame_last, o_res.valid, "final byte gave no result word")

endmodule
